// ===== rtl/srpg_pkg.sv =====
// Shared types, codes and constants of the Spectrum raster pixel generator.
package srpg_pkg;

    localparam int CELL_COLUMNS_DEF = 32;
    localparam int CELL_ROWS_DEF    = 24;

    localparam int BITMAP_DEPTH = 6144;
    localparam int ATTR_DEPTH   = 768;
    localparam int BMP_AW       = $clog2(BITMAP_DEPTH);
    localparam int ATTR_AW      = $clog2(ATTR_DEPTH);

    // The queue depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);

    typedef logic [1:0] t_op;
    localparam t_op OP_WR_BITMAP = 2'd0;
    localparam t_op OP_WR_ATTR   = 2'd1;
    localparam t_op OP_RENDER    = 2'd2;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_BORDER_COLOR  = 2'd0;
    localparam t_cfg_idx CFG_SYNC_BITS     = 2'd1;
    localparam t_cfg_idx CFG_BORDER_HEIGHT = 2'd2;
    localparam t_cfg_idx CFG_BORDER_WIDTH  = 2'd3;

    localparam logic [7:0] BORDER_HEIGHT_RST = 8'd24;
    localparam logic [7:0] BORDER_WIDTH_RST  = 8'd32;

    typedef enum logic [1:0] {
        K_WR_BMP,
        K_WR_ATTR,
        K_BORDER,
        K_PIXEL
    } t_kind;

    typedef struct packed {
        logic [7:0] border_color;
        logic [7:0] sync_bits;
        logic [7:0] border_height;
        logic [7:0] border_width;
    } t_cfg;

    typedef struct packed {
        t_kind              kind;
        logic               bmp_ok;
        logic [BMP_AW-1:0]  bmp_idx;
        logic               attr_ok;
        logic [ATTR_AW-1:0] attr_idx;
        logic [2:0]         bit_sel;
        logic [15:0]        data;
    } t_cmd;

endpackage

// ===== rtl/srpg_front.sv =====
// Front end: classifies an input beat and works out the store addresses.
module srpg_front #(
    parameter int CELL_COLUMNS = srpg_pkg::CELL_COLUMNS_DEF,
    parameter int CELL_ROWS    = srpg_pkg::CELL_ROWS_DEF
) (
    input  srpg_pkg::t_op  i_op,
    input  logic [12:0]    i_address,
    input  logic [15:0]    i_write_data,
    input  logic [9:0]     i_scanline,
    input  logic [9:0]     i_pixel_x,
    input  srpg_pkg::t_cfg i_cfg,
    output logic           o_cmd_valid,
    output srpg_pkg::t_cmd o_cmd
);

    logic [9:0]  h, top, bottom, dv;
    logic [9:0]  left, right, dx;
    logic        in_v, in_h;
    logic [7:0]  v;
    logic [8:0]  x;
    logic [5:0]  col;
    logic [12:0] line_addr;
    logic [13:0] baddr;
    logic [11:0] aaddr;

    always_comb begin
        h      = {1'b0, i_scanline[9:1]};
        top    = {2'b00, i_cfg.border_height};
        bottom = top + 10'(CELL_ROWS * 8);
        in_v   = (h >= top) && (h < bottom);
        dv     = h - top;
        v      = dv[7:0];

        left  = {2'b00, i_cfg.border_width};
        right = left + 10'(CELL_COLUMNS * 8);
        in_h  = (i_pixel_x >= left) && (i_pixel_x < right);
        dx    = i_pixel_x - left;
        x     = dx[8:0];
        col   = x[8:3];

        line_addr = {v[7:6], v[2:0], v[5:3], 5'b00000};
        baddr     = {1'b0, line_addr} + 14'(col);
        aaddr     = 12'(v[7:3]) * 12'(CELL_COLUMNS) + 12'(col);

        o_cmd_valid   = 1'b1;
        o_cmd.data    = i_write_data;
        o_cmd.bit_sel = x[2:0];
        case (i_op)
            srpg_pkg::OP_WR_BITMAP: begin
                o_cmd.kind     = srpg_pkg::K_WR_BMP;
                o_cmd.bmp_ok   = i_address < 13'(srpg_pkg::BITMAP_DEPTH);
                o_cmd.attr_ok  = 1'b0;
                o_cmd.bmp_idx  = i_address[srpg_pkg::BMP_AW-1:0];
                o_cmd.attr_idx = i_address[srpg_pkg::ATTR_AW-1:0];
            end
            srpg_pkg::OP_WR_ATTR: begin
                o_cmd.kind     = srpg_pkg::K_WR_ATTR;
                o_cmd.bmp_ok   = 1'b0;
                o_cmd.attr_ok  = i_address < 13'(srpg_pkg::ATTR_DEPTH);
                o_cmd.bmp_idx  = i_address[srpg_pkg::BMP_AW-1:0];
                o_cmd.attr_idx = i_address[srpg_pkg::ATTR_AW-1:0];
            end
            srpg_pkg::OP_RENDER: begin
                o_cmd.kind     = (in_v && in_h) ? srpg_pkg::K_PIXEL : srpg_pkg::K_BORDER;
                o_cmd.bmp_ok   = baddr < 14'(srpg_pkg::BITMAP_DEPTH);
                o_cmd.attr_ok  = aaddr < 12'(srpg_pkg::ATTR_DEPTH);
                o_cmd.bmp_idx  = baddr[srpg_pkg::BMP_AW-1:0];
                o_cmd.attr_idx = aaddr[srpg_pkg::ATTR_AW-1:0];
            end
            default: begin
                o_cmd_valid    = 1'b0;
                o_cmd.kind     = srpg_pkg::K_BORDER;
                o_cmd.bmp_ok   = 1'b0;
                o_cmd.attr_ok  = 1'b0;
                o_cmd.bmp_idx  = i_address[srpg_pkg::BMP_AW-1:0];
                o_cmd.attr_idx = i_address[srpg_pkg::ATTR_AW-1:0];
            end
        endcase
    end

endmodule

// ===== rtl/srpg_queue.sv =====
// Short command queue between the front end and the back end.
module srpg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  srpg_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output srpg_pkg::t_cmd o_cmd,
    input  logic           i_pop
);

    srpg_pkg::t_cmd              r_mem [srpg_pkg::QUEUE_DEPTH];
    logic [srpg_pkg::QP_W-1:0]   r_wr, r_rd;
    logic [srpg_pkg::QP_W:0]     r_count, n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_full  = r_count == (srpg_pkg::QP_W + 1)'(srpg_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd];

endmodule

// ===== rtl/srpg_back.sv =====
// Back end: store writes, store reads, color selection and output register.
module srpg_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  srpg_pkg::t_cfg i_cfg,
    input  logic           i_q_valid,
    input  srpg_pkg::t_cmd i_q_cmd,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_pixel_color
);

    logic [7:0]  r_bmp_mem  [srpg_pkg::BITMAP_DEPTH];
    logic [15:0] r_attr_mem [srpg_pkg::ATTR_DEPTH];

    logic        r_s1_valid, r_s1_border, r_s1_bmp_ok, r_s1_attr_ok;
    logic [2:0]  r_s1_bit;
    logic [7:0]  r_bmp_q;
    logic [15:0] r_attr_q;
    logic        r_out_valid;
    logic [7:0]  r_out_color;

    logic        out_ready, s1_free, is_render, pix;
    logic [7:0]  bits, color;
    logic [15:0] attr;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign s1_free   = !r_s1_valid || out_ready;
    assign o_pop     = i_q_valid && s1_free;
    assign is_render = (i_q_cmd.kind == srpg_pkg::K_PIXEL) ||
                       (i_q_cmd.kind == srpg_pkg::K_BORDER);

    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_cmd.kind == srpg_pkg::K_WR_BMP && i_q_cmd.bmp_ok) begin
            r_bmp_mem[i_q_cmd.bmp_idx] <= i_q_cmd.data[7:0];
        end
        if (o_pop && i_q_cmd.kind == srpg_pkg::K_PIXEL) begin
            r_bmp_q <= r_bmp_mem[i_q_cmd.bmp_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_cmd.kind == srpg_pkg::K_WR_ATTR && i_q_cmd.attr_ok) begin
            r_attr_mem[i_q_cmd.attr_idx] <= i_q_cmd.data;
        end
        if (o_pop && i_q_cmd.kind == srpg_pkg::K_PIXEL) begin
            r_attr_q <= r_attr_mem[i_q_cmd.attr_idx];
        end
    end

    always_comb begin
        bits  = r_s1_bmp_ok ? r_bmp_q : 8'h00;
        attr  = r_s1_attr_ok ? r_attr_q : 16'h0000;
        pix   = bits[3'd7 - r_s1_bit];
        color = r_s1_border ? i_cfg.border_color : (pix ? attr[15:8] : attr[7:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= o_pop && is_render;
            end
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_border  <= i_q_cmd.kind == srpg_pkg::K_BORDER;
            r_s1_bmp_ok  <= i_q_cmd.bmp_ok;
            r_s1_attr_ok <= i_q_cmd.attr_ok;
            r_s1_bit     <= i_q_cmd.bit_sel;
        end
        if (out_ready && r_s1_valid) begin
            r_out_color <= i_cfg.sync_bits | color;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_color = r_out_color;

endmodule

// ===== rtl/spectrum_raster_pixel_generator.sv =====
// Usage: the input channel carries one beat per item (i_op, i_address,
// i_write_data, i_scanline, i_pixel_x), taken when i_in_valid is high and
// o_in_stall is low. Op codes write a bitmap byte, write an attribute word,
// or render one pixel; only render beats produce an output beat.
// The output channel presents o_pixel_color with o_out_valid and holds it
// while i_out_stall is high. Registers are written through the cfg channel,
// which is always ready; the user must write them only while the block is
// idle, as the block itself does not enforce this. A render beat passes
// through the command queue, the s1 store read stage and the output register.
// The block takes one beat per cycle when the output is not stalled; a
// two-entry command queue between the classifier and the store back end
// absorbs stalls, and o_in_stall rises when that queue is full.
// Synchronous reset empties the queue and the output stage and loads the
// register reset values; the bitmap and attribute stores are not cleared
// and must be loaded before they are rendered.
module spectrum_raster_pixel_generator #(
    parameter int CELL_COLUMNS = srpg_pkg::CELL_COLUMNS_DEF,
    parameter int CELL_ROWS    = srpg_pkg::CELL_ROWS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  srpg_pkg::t_op       i_op,
    input  logic [12:0]         i_address,
    input  logic [15:0]         i_write_data,
    input  logic [9:0]          i_scanline,
    input  logic [9:0]          i_pixel_x,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [7:0]          o_pixel_color,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  srpg_pkg::t_cfg_idx  i_cfg_index,
    input  logic [7:0]          i_cfg_data
);

    srpg_pkg::t_cfg r_cfg;
    srpg_pkg::t_cmd w_front_cmd, w_q_cmd;
    logic           w_front_valid, w_push, w_full, w_q_valid, w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.border_color  <= 8'h00;
            r_cfg.sync_bits     <= 8'h00;
            r_cfg.border_height <= srpg_pkg::BORDER_HEIGHT_RST;
            r_cfg.border_width  <= srpg_pkg::BORDER_WIDTH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                srpg_pkg::CFG_BORDER_COLOR:  r_cfg.border_color  <= i_cfg_data;
                srpg_pkg::CFG_SYNC_BITS:     r_cfg.sync_bits     <= i_cfg_data;
                srpg_pkg::CFG_BORDER_HEIGHT: r_cfg.border_height <= i_cfg_data;
                srpg_pkg::CFG_BORDER_WIDTH:  r_cfg.border_width  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    srpg_front #(
        .CELL_COLUMNS (CELL_COLUMNS),
        .CELL_ROWS    (CELL_ROWS)
    ) u_front (
        .i_op         (i_op),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_scanline   (i_scanline),
        .i_pixel_x    (i_pixel_x),
        .i_cfg        (r_cfg),
        .o_cmd_valid  (w_front_valid),
        .o_cmd        (w_front_cmd)
    );

    assign o_in_stall = w_full;
    assign w_push     = i_in_valid && !w_full && w_front_valid;

    srpg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    srpg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (w_q_valid),
        .i_q_cmd       (w_q_cmd),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_color (o_pixel_color)
    );

`ifndef SYNTH
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("Pipeline not empty after reset.");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("Queue popped while empty.");

    a_full_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(w_push))
        else $error("Queue became full without a push.");
`endif

endmodule
